// ----- rtl/sadm_pkg.sv -----
package sadm_pkg;

   // Memory geometry: four byte lanes, one 32-bit row per aligned word
   localparam int MEM_BYTES  = 65536;
   localparam int MEM_ADDR_W = $clog2(MEM_BYTES);
   localparam int LANES      = 4;
   localparam int ROWS       = MEM_BYTES / LANES;
   localparam int ROW_W      = MEM_ADDR_W - 2;

   localparam int SIZE_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] BYTE_MASK = 8'hff;

   localparam logic [CSR_IDX_W-1:0] CSR_MSB_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE = 2'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_STORE = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_MISALIGNED   = 2'd1,
      STATUS_OUT_OF_BOUNDS = 2'd2
   } status_type;

   typedef struct packed {
      logic               kind;
      logic [1:0]         access_size;
      logic [31:0]        address;
      logic signed [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_data;
      status_type         status;
   } rsp_type;

   // Decoded access: memory controls plus what the load formatter needs
   typedef struct packed {
      status_type         status;
      logic               rd_en;
      logic [LANES-1:0]   wr_en;
      logic [ROW_W-1:0]   row;
      logic [31:0]        wr_data;
      logic [1:0]         size;
      logic [1:0]         lane;
   } dec_type;

endpackage

// ----- rtl/sized_access_data_memory.sv -----
// A result strobes on rsp_valid once the start transfer has passed the stage 1 and result registers.
// Throughput: one load or store per cycle; busy stays low, since the single
// memory port is used once per item and a store lands before the next read.
// Reset (synchronous, active high) clears the pipeline valids and loads
// big-endian mode and the full size in use; memory contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sized_access_data_memory
   import sadm_pkg::*;
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  start,
    output logic                  busy,
    input  req_type               req_payload,
    output logic                  rsp_valid,
    output rsp_type               rsp_payload,
    input  logic                  csr_valid,
    output logic                  csr_ready,
    input  logic [CSR_IDX_W-1:0]  csr_index,
    input  logic [CSR_DATA_W-1:0] csr_wdata);

   // Configuration registers
   logic              msb_first_ff, msb_first_in;
   logic [SIZE_W-1:0] size_in_use_ff, size_in_use_in;

   // Stage 1: memory read in flight
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_load_ff, s1_load_in;
   logic       s1_msb_first_ff, s1_msb_first_in;
   status_type s1_status_ff, s1_status_in;
   logic [1:0] s1_size_ff, s1_size_in;
   logic [1:0] s1_lane_ff, s1_lane_in;

   // Stage 2: result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic        accept;
   dec_type     dec;
   logic [3:0]  ram_wr_en;
   logic [31:0] ram_rd_data;
   logic [15:0] half_pair;
   logic [7:0]  byte_val;
   logic [31:0] load_val;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   sadm_decode u_decode (
      .req         (req_payload),
      .msb_first   (msb_first_ff),
      .size_in_use (size_in_use_ff),
      .dec         (dec));

   // Only accepted items touch the memory
   assign ram_wr_en = accept ? dec.wr_en : 4'b0000;

   sadm_ram #(.DEPTH(ROWS), .ADDR_W(ROW_W)) u_ram (
      .clock   (clock),
      .rd_en   (accept && dec.rd_en),
      .wr_en   (ram_wr_en),
      .addr    (dec.row),
      .wr_data (dec.wr_data),
      .rd_data (ram_rd_data));

   // Configuration writes; unknown indexes drop
   always_comb begin
      msb_first_in   = msb_first_ff;
      size_in_use_in = size_in_use_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MSB_FIRST:   msb_first_in   = csr_wdata[0];
            CSR_SIZE_IN_USE: size_in_use_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture what the formatter needs while the read completes
   always_comb begin
      s1_valid_in     = accept;
      s1_load_in      = dec.rd_en;
      s1_msb_first_in = msb_first_ff;
      s1_status_in    = dec.status;
      s1_size_in      = dec.size;
      s1_lane_in      = dec.lane;
   end

   // Assemble the loaded value from the byte lanes and sign-extend it
   always_comb begin
      half_pair = s1_lane_ff[1] ? ram_rd_data[31:16] : ram_rd_data[15:0];
      case (s1_lane_ff)
         2'd0:    byte_val = ram_rd_data[7:0];
         2'd1:    byte_val = ram_rd_data[15:8];
         2'd2:    byte_val = ram_rd_data[23:16];
         default: byte_val = ram_rd_data[31:24];
      endcase

      case (s1_size_ff)
         SIZE_BYTE: load_val = {{24{byte_val[7]}}, byte_val};
         SIZE_HALF: begin
            if (s1_msb_first_ff) begin
               load_val = {{16{half_pair[7]}}, half_pair[7:0], half_pair[15:8]};
            end else begin
               load_val = {{16{half_pair[15]}}, half_pair};
            end
         end
         default: begin
            load_val = s1_msb_first_ff
                     ? {ram_rd_data[7:0], ram_rd_data[15:8],
                        ram_rd_data[23:16], ram_rd_data[31:24]}
                     : ram_rd_data;
         end
      endcase

      rsp_valid_in     = s1_valid_ff;
      rsp_in.status    = s1_status_ff;
      // stores and faults return zero
      rsp_in.read_data = s1_load_ff ? load_val : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msb_first_ff   <= 1'b1;
         size_in_use_ff <= SIZE_W'(MEM_BYTES);
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         msb_first_ff   <= msb_first_in;
         size_in_use_ff <= size_in_use_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_load_ff      <= s1_load_in;
      s1_msb_first_ff <= s1_msb_first_in;
      s1_status_ff    <= s1_status_in;
      s1_size_ff      <= s1_size_in;
      s1_lane_ff      <= s1_lane_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Every result traces back to an accepted transfer, through the stage 1 and result registers
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without a matching transfer");

   // A failing access never writes the memory
   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      (dec.status != STATUS_OK) |-> (ram_wr_en == 4'b0000))
      else $error("faulting access wrote memory");

   // A failed access returns zero data
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_OK) |-> (rsp_payload.read_data == 32'd0))
      else $error("faulting access returned data");

   // Writes cover one, two or four lanes, never a load
   a_lane_count: assert property (@(posedge clock) disable iff (reset)
      ($countones(ram_wr_en) == 0 || $countones(ram_wr_en) == 1 ||
       $countones(ram_wr_en) == 2 || $countones(ram_wr_en) == 4) &&
      !(ram_wr_en != 4'b0000 && dec.rd_en))
      else $error("bad byte enable pattern");

endmodule

// ----- rtl/sadm_ram.sv -----
module sadm_ram
   #(parameter int DEPTH  = 16384,
     parameter int ADDR_W = $clog2(DEPTH))
   (input  logic              clock,
    input  logic              rd_en,
    input  logic [3:0]        wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [31:0]       wr_data,
    output logic [31:0]       rd_data);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         if (wr_en[l]) begin
            mem[addr][8*l +: 8] <= wr_data[8*l +: 8];
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sadm_decode.sv -----
module sadm_decode
   import sadm_pkg::*;
   (input  req_type           req,
    input  logic              msb_first,
    input  logic [SIZE_W-1:0] size_in_use,
    output dec_type           dec);

   logic [1:0]  size;
   logic [2:0]  nbytes;
   logic        misaligned;
   logic [32:0] end_addr;
   logic [32:0] limit;
   logic [15:0] half_val;
   logic        ok;

   always_comb begin
      // size code three acts as a word
      if (req.access_size == SIZE_BYTE) begin
         size = SIZE_BYTE;
      end else if (req.access_size == SIZE_HALF) begin
         size = SIZE_HALF;
      end else begin
         size = SIZE_WORD;
      end

      case (size)
         SIZE_BYTE: begin
            nbytes     = 3'd1;
            misaligned = 1'b0;
         end
         SIZE_HALF: begin
            nbytes     = 3'd2;
            misaligned = req.address[0];
         end
         default: begin
            nbytes     = 3'd4;
            misaligned = req.address[1:0] != 2'd0;
         end
      endcase

      end_addr = {1'b0, req.address} + 33'(nbytes);
      limit    = (33'(size_in_use) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES) : 33'(size_in_use);

      if (misaligned) begin
         dec.status = STATUS_MISALIGNED;
      end else if (end_addr > limit) begin
         dec.status = STATUS_OUT_OF_BOUNDS;
      end else begin
         dec.status = STATUS_OK;
      end
      ok = dec.status == STATUS_OK;

      dec.row  = req.address[MEM_ADDR_W-1:2];
      dec.size = size;
      dec.lane = req.address[1:0];
      dec.rd_en = ok && (req.kind == KIND_LOAD);

      half_val = msb_first ? {req.write_data[7:0], req.write_data[15:8]}
                           : req.write_data[15:0];

      // lane l holds the byte at the row's address plus l
      case (size)
         SIZE_BYTE: begin
            dec.wr_data = {4{req.write_data[7:0] & BYTE_MASK}};
            dec.wr_en   = 4'b0001 << req.address[1:0];
         end
         SIZE_HALF: begin
            dec.wr_data = {half_val, half_val};
            dec.wr_en   = req.address[1] ? 4'b1100 : 4'b0011;
         end
         default: begin
            dec.wr_data = msb_first ? {req.write_data[7:0], req.write_data[15:8],
                                       req.write_data[23:16], req.write_data[31:24]}
                                    : req.write_data;
            dec.wr_en   = 4'b1111;
         end
      endcase

      if (!(ok && (req.kind == KIND_STORE))) begin
         dec.wr_en = 4'b0000;
      end
   end

endmodule

// ----- dv/sized_access_data_memory_test.sv -----
module sized_access_data_memory_test;
   import sadm_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   // Delay from a start transfer to its result strobe, in clock cycles.
   localparam int LATENCY        = 2;
   localparam int SETTLE_CYCLES  = LATENCY + 3;
   // Commands left in the plan when sender idling stops for good.
   localparam int TAIL_CMDS      = 120;
   localparam int RANDOM_PER_SET = 90;
   localparam int TIMEOUT_CYCLES = 200000;

   // Register indexes that decode to nothing; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // Unused size code; the block treats it as a word.
   localparam logic [1:0] SIZE_WORD_ALIAS = 2'd3;

   typedef enum logic [1:0] {
      CMD_ACCESS,
      CMD_CSR,
      CMD_SETTLE
   } cmd_op_type;

   typedef struct {
      cmd_op_type              op;
      req_type                 req;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   data;
   } cmd_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   sized_access_data_memory i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata));

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Planned commands, filled up front and drained by the driver.
   cmd_type cmd_q[$];
   // Responses owed by the block, oldest first.
   rsp_type due_rsp_q[$];

   // Predicted memory contents and register copies, updated on transfers.
   logic [7:0]         mem_image [MEM_BYTES];
   logic               endian_big = 1'b1;
   logic [SIZE_W-1:0]  size_reg   = SIZE_W'(MEM_BYTES);

   // Planning-time view: which bytes will hold data, and the size in force.
   bit                 byte_written [MEM_BYTES];
   logic [SIZE_W-1:0]  plan_size = SIZE_W'(MEM_BYTES);

   int bad_count    = 0;
   int load_count   = 0;
   int store_count  = 0;
   int misalign_cnt = 0;
   int oob_count    = 0;
   int csr_count    = 0;
   int setting_cnt  = 1;

   // Driver bookkeeping
   int gap_left     = 0;
   bit gap_served   = 1'b0;
   int settle_count = 0;
   int idle_pct     = 0;
   int access_run   = 0;
   bit stim_done    = 1'b0;

   // ------------------------------------------------------------------
   // Access decode shared by the planner and the predictor
   // ------------------------------------------------------------------

   function automatic int unsigned span_bytes(logic [1:0] sz);
      // Size code three behaves as a word.
      return (sz == SIZE_BYTE) ? 1 : (sz == SIZE_HALF) ? 2 : 4;
   endfunction

   // A size in use past the end of the array acts as the whole array.
   function automatic longint usable_bytes(logic [SIZE_W-1:0] s);
      return (s > MEM_BYTES) ? longint'(MEM_BYTES) : longint'(s);
   endfunction

   // Alignment wins over bounds; the bounds test covers the last byte.
   function automatic status_type access_fault(logic [1:0] sz, logic [31:0] addr,
                                               longint lim);
      int unsigned n;
      n = span_bytes(sz);
      if ((addr & (n - 1)) != 0)
         return STATUS_MISALIGNED;
      if (longint'(addr) + n > lim)
         return STATUS_OUT_OF_BOUNDS;
      return STATUS_OK;
   endfunction

   // Apply one transfer to the memory image and return the response it owes.
   function automatic rsp_type perform_access(req_type r);
      rsp_type     res;
      int unsigned n;
      int unsigned a;
      int unsigned sh;
      logic [31:0] v;
      n = span_bytes(r.access_size);
      res.read_data = '0;
      res.status = access_fault(r.access_size, r.address, usable_bytes(size_reg));
      if (res.status == STATUS_OK) begin
         a = r.address[MEM_ADDR_W-1:0];
         v = '0;
         for (int i = 0; i < n; i++) begin
            sh = endian_big ? 8 * (n - 1 - i) : 8 * i;
            if (r.kind == KIND_STORE)
               mem_image[a + i] = 8'(r.write_data >> sh) & BYTE_MASK;
            else
               v = v | (32'(mem_image[a + i]) << sh);
         end
         if (n == 1)
            v = {{24{v[7]}}, v[7:0]};
         else if (n == 2)
            v = {{16{v[15]}}, v[15:0]};
         if (r.kind == KIND_LOAD)
            res.read_data = v;
      end
      return res;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      bad_count++;
      if (bad_count <= 10)
         $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
   endtask

   // ------------------------------------------------------------------
   // Planning
   // ------------------------------------------------------------------

   // Queue one access. A load that would touch bytes never stored becomes
   // a store, so no never-written byte is ever read.
   task automatic plan_access(logic kind, logic [1:0] sz, logic [31:0] addr,
                              logic [31:0] data);
      cmd_type     cmd;
      int unsigned n;
      int unsigned a;
      bit          ready;
      n = span_bytes(sz);
      cmd.op = CMD_ACCESS;
      cmd.index = '0;
      cmd.data = '0;
      if (access_fault(sz, addr, usable_bytes(plan_size)) == STATUS_OK) begin
         a = addr[MEM_ADDR_W-1:0];
         ready = 1'b1;
         for (int i = 0; i < n; i++)
            ready = ready & byte_written[a + i];
         if (kind == KIND_LOAD && !ready)
            kind = KIND_STORE;
         if (kind == KIND_STORE)
            for (int i = 0; i < n; i++)
               byte_written[a + i] = 1'b1;
      end
      cmd.req.kind = kind;
      cmd.req.access_size = sz;
      cmd.req.address = addr;
      cmd.req.write_data = data;
      cmd_q.push_back(cmd);
   endtask

   task automatic plan_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      cmd_type cmd;
      cmd.op = CMD_CSR;
      cmd.req = '0;
      cmd.index = index;
      cmd.data = data;
      if (index == CSR_SIZE_IN_USE)
         plan_size = data[SIZE_W-1:0];
      cmd_q.push_back(cmd);
   endtask

   // Quiesce, then write both registers.
   task automatic plan_setting(logic [CSR_DATA_W-1:0] endian_word,
                               logic [CSR_DATA_W-1:0] size_word);
      cmd_type cmd;
      cmd.op = CMD_SETTLE;
      cmd.req = '0;
      cmd.index = '0;
      cmd.data = '0;
      cmd_q.push_back(cmd);
      plan_csr(CSR_MSB_FIRST, endian_word);
      plan_csr(CSR_SIZE_IN_USE, size_word);
      setting_cnt++;
   endtask

   // Most addresses land in a low window or straddle the end of the usable
   // range; the rest are anywhere in the 32-bit space and mostly fault.
   task automatic plan_random(int count);
      longint      lim;
      int unsigned hot_top;
      int unsigned n;
      logic [1:0]  sz;
      logic [31:0] addr;
      logic [31:0] data;
      int          pick;
      for (int k = 0; k < count; k++) begin
         lim = usable_bytes(plan_size);
         hot_top = ((lim < 512) ? int'(lim) : 512) + 3;
         pick = $urandom_range(0, 9);
         sz = (pick < 3) ? SIZE_BYTE : (pick < 6) ? SIZE_HALF : (pick < 9) ? SIZE_WORD
                         : SIZE_WORD_ALIAS;
         n = span_bytes(sz);
         pick = $urandom_range(0, 99);
         if (pick < 65)
            addr = $urandom_range(0, hot_top);
         else if (pick < 85)
            addr = 32'(lim) + 32'($urandom_range(0, 11)) - 32'd8;
         else
            addr = $urandom();
         if ($urandom_range(0, 99) < 85)
            addr = addr & ~32'(n - 1);
         case ($urandom_range(0, 19))
            0:       data = 32'h0000_0000;
            1:       data = 32'hffff_ffff;
            2:       data = 32'h8000_0000;
            3:       data = 32'h7fff_ffff;
            default: data = $urandom();
         endcase
         plan_access(($urandom_range(0, 1) == 1) ? KIND_STORE : KIND_LOAD, sz, addr, data);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: present the next planned command, hold it until its transfer,
   // and drop in idle gaps of random length before accesses.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      cmd_type cmd;
      bit      hold;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         hold = (start && busy) || (csr_valid && !csr_ready);
         if (hold) begin
            // keep the current command on the ports
         end else if (gap_left > 0) begin
            gap_left--;
            start     <= 1'b0;
            csr_valid <= 1'b0;
         end else if (cmd_q.size() == 0) begin
            start     <= 1'b0;
            csr_valid <= 1'b0;
            stim_done <= 1'b1;
         end else begin
            case (cmd_q[0].op)
               CMD_ACCESS: begin
                  csr_valid <= 1'b0;
                  if (!gap_served && idle_pct != 0 && cmd_q.size() > TAIL_CMDS &&
                      $urandom_range(0, 99) < idle_pct) begin
                     // this cycle is the first of the gap
                     gap_left   = $urandom_range(1, 4) - 1;
                     gap_served = 1'b1;
                     start     <= 1'b0;
                  end else begin
                     cmd = cmd_q.pop_front();
                     gap_served = 1'b0;
                     start       <= 1'b1;
                     req_payload <= cmd.req;
                     // switch idling density now and then, quiet stretches included
                     access_run++;
                     if (access_run % 48 == 0)
                        case ($urandom_range(0, 3))
                           0, 1:    idle_pct = 0;
                           2:       idle_pct = 20;
                           default: idle_pct = 50;
                        endcase
                  end
               end
               CMD_CSR: begin
                  cmd = cmd_q.pop_front();
                  start     <= 1'b0;
                  csr_valid <= 1'b1;
                  csr_index <= cmd.index;
                  csr_wdata <= cmd.data;
               end
               default: begin
                  // Hold off until nothing is owed for several cycles in a row;
                  // a lone empty reading could miss a push made at this edge.
                  start     <= 1'b0;
                  csr_valid <= 1'b0;
                  if (due_rsp_q.size() == 0)
                     settle_count++;
                  else
                     settle_count = 0;
                  if (settle_count >= SETTLE_CYCLES) begin
                     settle_count = 0;
                     void'(cmd_q.pop_front());
                  end
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each strobed result against the oldest owed response,
   // then track register writes and predict newly accepted transfers.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_proc
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_rsp_q.size() == 0) begin
               note_mismatch("result with nothing owed", '0, rsp_payload.read_data);
            end else begin
               want = due_rsp_q.pop_front();
               if (rsp_payload.read_data !== want.read_data)
                  note_mismatch("read_data", want.read_data, rsp_payload.read_data);
               if (rsp_payload.status !== want.status)
                  note_mismatch("status", 32'(want.status), 32'(rsp_payload.status));
            end
         end
         if (csr_valid && csr_ready) begin
            csr_count++;
            case (csr_index)
               CSR_MSB_FIRST:   endian_big = csr_wdata[0];
               CSR_SIZE_IN_USE: size_reg = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            want = perform_access(req_payload);
            case (want.status)
               STATUS_MISALIGNED:    misalign_cnt++;
               STATUS_OUT_OF_BOUNDS: oob_count++;
               default:
                  if (req_payload.kind == KIND_STORE)
                     store_count++;
                  else
                     load_count++;
            endcase
            due_rsp_q.push_back(want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Plan the whole run, release reset, wait for the tail, report.
   // ------------------------------------------------------------------
   initial begin
      // Reset settings: big-endian, full size.
      // Sign extension of halves and bytes, big-endian packing.
      plan_access(KIND_STORE, SIZE_WORD, 32'd0, 32'h80ff_7f01);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'd0, 32'h0);
      plan_access(KIND_LOAD,  SIZE_HALF, 32'd0, 32'h0);
      plan_access(KIND_LOAD,  SIZE_HALF, 32'd2, 32'h0);
      plan_access(KIND_LOAD,  SIZE_BYTE, 32'd1, 32'h0);
      plan_access(KIND_LOAD,  SIZE_BYTE, 32'd2, 32'h0);
      // Narrow stores use only the low bits of the data.
      plan_access(KIND_STORE, SIZE_HALF, 32'd4, 32'h1234_8001);
      plan_access(KIND_STORE, SIZE_BYTE, 32'd6, 32'haaaa_aa80);
      plan_access(KIND_STORE, SIZE_BYTE, 32'd7, 32'h5555_557f);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'd4, 32'h0);
      // Last word of memory, then just past it and at the top of the space.
      plan_access(KIND_STORE, SIZE_WORD, 32'd65532, 32'hffff_ffff);
      plan_access(KIND_LOAD,  SIZE_BYTE, 32'd65535, 32'h0);
      plan_access(KIND_STORE, SIZE_WORD, 32'd65536, 32'h1111_1111);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'hffff_fffc, 32'h0);
      plan_access(KIND_STORE, SIZE_BYTE, 32'hffff_ffff, 32'h0000_00ff);
      // Misaligned and out of bounds at once reports misaligned.
      plan_access(KIND_LOAD,  SIZE_WORD, 32'hffff_fffd, 32'h0);
      plan_access(KIND_STORE, SIZE_WORD, 32'd2, 32'hdead_beef);
      plan_access(KIND_STORE, SIZE_HALF, 32'd3, 32'hdead_beef);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'd1, 32'h0);
      // Size code three acts as a word, alignment included.
      plan_access(KIND_STORE, SIZE_WORD_ALIAS, 32'd8, 32'h0000_0000);
      plan_access(KIND_LOAD,  SIZE_WORD_ALIAS, 32'd8, 32'h0);
      plan_access(KIND_LOAD,  SIZE_WORD_ALIAS, 32'd10, 32'h0);
      plan_access(KIND_STORE, SIZE_WORD, 32'd12, 32'h7fff_ffff);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'd12, 32'h0);
      plan_random(RANDOM_PER_SET);

      // Little-endian view of the same bytes.
      plan_setting(32'd0, 32'd65536);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'd0, 32'h0);
      plan_access(KIND_LOAD,  SIZE_HALF, 32'd0, 32'h0);
      plan_access(KIND_LOAD,  SIZE_HALF, 32'd4, 32'h0);
      plan_random(RANDOM_PER_SET);

      // Partial overlap: first byte in range, last one not; nothing written.
      plan_setting(32'd1, 32'd10);
      plan_access(KIND_LOAD,  SIZE_WORD, 32'd8, 32'h0);
      plan_access(KIND_STORE, SIZE_HALF, 32'd10, 32'h0000_5a5a);
      plan_access(KIND_STORE, SIZE_WORD, 32'd8, 32'h1234_5678);
      plan_access(KIND_LOAD,  SIZE_BYTE, 32'd9, 32'h0);
      plan_access(KIND_LOAD,  SIZE_HALF, 32'd8, 32'h0);
      plan_random(RANDOM_PER_SET);

      plan_setting(32'd0, 32'd1);
      plan_random(RANDOM_PER_SET);

      // Size zero: every access faults.
      plan_setting(32'd1, 32'd0);
      plan_access(KIND_LOAD, SIZE_BYTE, 32'd0, 32'h0);
      plan_random(RANDOM_PER_SET);

      // Largest register value acts as the whole array.
      plan_setting(32'd0, 32'h0001_ffff);
      plan_access(KIND_LOAD, SIZE_WORD, 32'd65532, 32'h0);
      plan_random(RANDOM_PER_SET);

      // Upper write-data bits are ignored; spare indexes change nothing.
      plan_setting(32'hffff_fffe, 32'hfffe_012c);
      plan_csr(CSR_SPARE_2, $urandom());
      plan_csr(CSR_SPARE_3, $urandom());
      plan_random(RANDOM_PER_SET);

      plan_setting(32'd1, 32'd65535);
      plan_random(RANDOM_PER_SET);

      plan_setting(32'd0, 32'd65536);
      plan_random(RANDOM_PER_SET);

      plan_setting(32'd1, 32'd4096);
      plan_random(RANDOM_PER_SET);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!stim_done || due_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES + 3) @(posedge clock);
      if (due_rsp_q.size() != 0)
         note_mismatch("responses never seen", '0, 32'(due_rsp_q.size()));

      $display("covered %0d loads and %0d stores completed, %0d misaligned, %0d out of bounds",
               load_count, store_count, misalign_cnt, oob_count);
      $display("over %0d register settings with %0d register writes; %0d mismatches",
               setting_cnt, csr_count, bad_count);
      if (bad_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d responses owed", due_rsp_q.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
